/* rtl/itc_pkg.sv */
// Types and constants shared by the 3x3 image convolution block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package itc_pkg;

   localparam int PIX_W      = 8;
   localparam int COEF_W     = 8;
   localparam int NUM_TAPS   = 9;
   localparam int TAP_W      = 4;
   localparam int ACC_W      = 20;
   localparam int MAG_W      = 19;
   localparam int SCALE_W    = 24;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = MAG_W + SCALE_W;
   localparam int RES_ROW_W  = 12;
   localparam int RES_COL_W  = 11;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int IMG_W_W    = 12;
   localparam int IMG_H_W    = 13;
   localparam int KTM_W      = 48;
   localparam int KB_W       = 24;

   localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);
   localparam logic [PIX_W-1:0] SAT_MAX  = 8'd255;

   localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
   localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [KTM_W-1:0]   RST_KERNEL_TM    = 48'd2207881396737;
   localparam logic [KB_W-1:0]    RST_KERNEL_B     = 24'd66049;
   localparam logic [SCALE_W-1:0] RST_SCALE        = 24'd4096;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_TM    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_B     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE        = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MAC,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_DRAIN,
      SEL_PASS,
      SEL_FILT
   } out_sel_type;

   typedef struct packed {
      logic             accept;
      logic             pixel_step;
      logic             mac_en;
      logic             mac_first;
      logic [TAP_W-1:0] tap;
      logic             scale_en;
      logic             load_out;
      out_sel_type      out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic drain;
      logic pending_zero;
      logic emit_due;
      logic interior;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/itc_req_if.sv */
// Pixel input channel: valid/ready handshake with pixel and drain payload.
// Depends on itc_pkg for field widths.
`default_nettype none

interface itc_req_if;
   logic                       valid;
   logic                       ready;
   logic [itc_pkg::PIX_W-1:0]  pixel_value;
   logic                       drain;

   modport source (output valid, output pixel_value, output drain, input ready);
   modport sink   (input valid, input pixel_value, input drain, output ready);
endinterface

`default_nettype wire

/* rtl/itc_rsp_if.sv */
// Result channel: valid/ready handshake with value, position and frame end.
// Depends on itc_pkg for field widths.
`default_nettype none

interface itc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itc_pkg::PIX_W-1:0]     result_value;
   logic [itc_pkg::RES_ROW_W-1:0] result_row;
   logic [itc_pkg::RES_COL_W-1:0] result_column;
   logic                          frame_end;

   modport source (output valid, output result_value, output result_row,
                   output result_column, output frame_end, input ready);
   modport sink   (input valid, input result_value, input result_row,
                   input result_column, input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/itc_ctrl.sv */
// Sequencer of the convolution block: accepts a word, steps the datapath
// through update, then as needed MAC, scaling and result load. Uses itc_pkg.
`default_nettype none

module itc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire itc_pkg::dp_status_type status,
   output itc_pkg::dp_cmd_type         cmd
);

   itc_pkg::state_type                state_ff, state_in;
   logic [itc_pkg::TAP_W-1:0]         tap_ff, tap_in;
   itc_pkg::out_sel_type              out_sel_ff, out_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= itc_pkg::ST_IDLE;
         tap_ff     <= '0;
         out_sel_ff <= itc_pkg::SEL_PASS;
      end else begin
         state_ff   <= state_in;
         tap_ff     <= tap_in;
         out_sel_ff <= out_sel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      out_sel_in = out_sel_ff;
      unique case (state_ff)
         itc_pkg::ST_IDLE: begin
            if (req_valid) state_in = itc_pkg::ST_UPDATE;
         end
         itc_pkg::ST_UPDATE: begin
            if (status.drain) begin
               // drain with nothing pending gives no word
               if (status.pending_zero) begin
                  state_in = itc_pkg::ST_IDLE;
               end else begin
                  state_in   = itc_pkg::ST_OUT;
                  out_sel_in = itc_pkg::SEL_DRAIN;
               end
            end else if (!status.emit_due) begin
               state_in = itc_pkg::ST_IDLE;
            end else if (status.interior) begin
               state_in = itc_pkg::ST_MAC;
               tap_in   = '0;
            end else begin
               state_in   = itc_pkg::ST_OUT;
               out_sel_in = itc_pkg::SEL_PASS;
            end
         end
         itc_pkg::ST_MAC: begin
            tap_in = tap_ff + 1'b1;
            if (tap_ff == itc_pkg::LAST_TAP) state_in = itc_pkg::ST_SCALE;
         end
         itc_pkg::ST_SCALE: begin
            state_in   = itc_pkg::ST_OUT;
            out_sel_in = itc_pkg::SEL_FILT;
         end
         itc_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!status.out_busy) state_in = itc_pkg::ST_IDLE;
         end
         default: state_in = itc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == itc_pkg::ST_IDLE);
      cmd.accept     = (state_ff == itc_pkg::ST_IDLE) && req_valid;
      cmd.pixel_step = (state_ff == itc_pkg::ST_UPDATE) && !status.drain;
      cmd.mac_en     = (state_ff == itc_pkg::ST_MAC);
      cmd.mac_first  = (tap_ff == '0);
      cmd.tap        = tap_ff;
      cmd.scale_en   = (state_ff == itc_pkg::ST_SCALE);
      cmd.load_out   = (state_ff == itc_pkg::ST_OUT) && !status.out_busy;
      cmd.out_sel    = out_sel_ff;
   end

endmodule

`default_nettype wire

/* rtl/itc_datapath.sv */
// Datapath of the convolution block: config registers, two line memories,
// 3x3 window, position counters, shared MAC, scaler and output register.
// Uses itc_pkg; driven by itc_ctrl through command and status structs.
`default_nettype none

module itc_datapath #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [itc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [itc_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  wire logic [itc_pkg::PIX_W-1:0]         req_pixel_value,
   input  wire logic                              req_drain,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic [itc_pkg::PIX_W-1:0]              rsp_result_value,
   output logic [itc_pkg::RES_ROW_W-1:0]          rsp_result_row,
   output logic [itc_pkg::RES_COL_W-1:0]          rsp_result_column,
   output logic                                   rsp_frame_end,
   input  wire itc_pkg::dp_cmd_type               cmd,
   output itc_pkg::dp_status_type                 status
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);
   localparam int PW     = itc_pkg::PIX_W;

   // configuration
   logic [itc_pkg::IMG_W_W-1:0] image_width_ff;
   logic [itc_pkg::IMG_H_W-1:0] image_height_ff;
   logic [itc_pkg::KTM_W-1:0]   kernel_tm_ff;
   logic [itc_pkg::KB_W-1:0]    kernel_b_ff;
   logic [itc_pkg::SCALE_W-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= itc_pkg::RST_IMAGE_WIDTH;
         image_height_ff <= itc_pkg::RST_IMAGE_HEIGHT;
         kernel_tm_ff    <= itc_pkg::RST_KERNEL_TM;
         kernel_b_ff     <= itc_pkg::RST_KERNEL_B;
         scale_ff        <= itc_pkg::RST_SCALE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            itc_pkg::REG_IMAGE_WIDTH:
               image_width_ff <= csr_write_data[itc_pkg::IMG_W_W-1:0];
            itc_pkg::REG_IMAGE_HEIGHT:
               image_height_ff <= csr_write_data[itc_pkg::IMG_H_W-1:0];
            itc_pkg::REG_KERNEL_TM:
               kernel_tm_ff <= csr_write_data[itc_pkg::KTM_W-1:0];
            itc_pkg::REG_KERNEL_B:
               kernel_b_ff <= csr_write_data[itc_pkg::KB_W-1:0];
            itc_pkg::REG_SCALE:
               scale_ff <= csr_write_data[itc_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry: zero acts as one, clamp at the maximum
   logic [31:0] w_raw, h_raw, w_eff, h_eff;
   always_comb begin
      w_raw = 32'(image_width_ff);
      h_raw = 32'(image_height_ff);
      if (w_raw == 32'd0)                    w_eff = 32'd1;
      else if (w_raw > 32'(MAX_WIDTH))       w_eff = 32'(MAX_WIDTH);
      else                                   w_eff = w_raw;
      if (h_raw == 32'd0)                    h_eff = 32'd1;
      else if (h_raw > 32'(MAX_HEIGHT))      h_eff = 32'(MAX_HEIGHT);
      else                                   h_eff = h_raw;
   end

   // item latch
   logic [PW-1:0] pixel_ff;
   logic          drain_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pixel_ff <= req_pixel_value;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
      end else if (cmd.accept) begin
         drain_ff <= req_drain;
      end
   end

   // position counters and pending count
   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [31:0]       in_col32, in_row32, out_col32, out_row32, pend32;

   always_comb begin
      in_col32  = 32'(in_col_ff);
      in_row32  = 32'(in_row_ff);
      out_col32 = 32'(out_col_ff);
      out_row32 = 32'(out_row_ff);
      pend32    = 32'(pend_ff);

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in    = pend_ff;

      if (cmd.pixel_step) begin
         pend_in = pend_ff + 1'b1;
         if (in_col32 + 32'd1 >= w_eff) begin
            in_col_in = '0;
            if (in_row32 + 32'd1 >= h_eff) in_row_in = '0;
            else                           in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end

      if (cmd.load_out) begin
         pend_in = pend_ff - 1'b1;
         if (out_col32 + 32'd1 >= w_eff) begin
            out_col_in = '0;
            if (out_row32 + 32'd1 >= h_eff) out_row_in = '0;
            else                            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
      end
   end

   // line memories: read on accept, write back on pixel update
   logic [PW-1:0]    line_upper_ff [MAX_WIDTH];
   logic [PW-1:0]    line_lower_ff [MAX_WIDTH];
   logic [PW-1:0]    upper_q_ff, lower_q_ff;
   logic [COL_W-1:0] rd_addr;

   assign rd_addr = req_drain ? out_col_ff : in_col_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         upper_q_ff <= line_upper_ff[rd_addr];
         lower_q_ff <= line_lower_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pixel_step) begin
         line_upper_ff[in_col_ff] <= lower_q_ff;
         line_lower_ff[in_col_ff] <= pixel_ff;
      end
   end

   // 3x3 window, row-major, newest column at the right
   logic [PW-1:0] window_ff [itc_pkg::NUM_TAPS];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < itc_pkg::NUM_TAPS; i++) window_ff[i] <= '0;
      end else if (cmd.pixel_step) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r*3]     <= window_ff[r*3 + 1];
            window_ff[r*3 + 1] <= window_ff[r*3 + 2];
         end
         window_ff[2] <= upper_q_ff;
         window_ff[5] <= lower_q_ff;
         window_ff[8] <= pixel_ff;
      end
   end

   // shared multiply-accumulate, one tap per cycle
   logic [itc_pkg::NUM_TAPS*itc_pkg::COEF_W-1:0] kernel_all;
   logic signed [PW:0]                             mac_pix;
   logic signed [itc_pkg::COEF_W-1:0]              mac_coef;
   logic signed [PW+itc_pkg::COEF_W:0]             mac_prod;
   logic signed [itc_pkg::ACC_W-1:0]               acc_ff, acc_in;

   assign kernel_all = {kernel_b_ff, kernel_tm_ff};

   always_comb begin
      mac_pix  = signed'({1'b0, window_ff[cmd.tap]});
      mac_coef = signed'(kernel_all[cmd.tap*itc_pkg::COEF_W +: itc_pkg::COEF_W]);
      mac_prod = mac_pix * mac_coef;
      if (cmd.mac_first) acc_in = itc_pkg::ACC_W'(mac_prod);
      else               acc_in = acc_ff + itc_pkg::ACC_W'(mac_prod);
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_en) acc_ff <= acc_in;
   end

   // magnitude times Q8.16 factor
   logic [itc_pkg::MAG_W-1:0]  mag;
   logic [itc_pkg::PROD_W-1:0] prod_ff;
   logic [itc_pkg::PROD_W-itc_pkg::FRAC_W-1:0] scaled;
   logic [PW-1:0]              filt_value;

   always_comb begin
      if (acc_ff[itc_pkg::ACC_W-1]) mag = itc_pkg::MAG_W'(-acc_ff);
      else                          mag = itc_pkg::MAG_W'(acc_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.scale_en) prod_ff <= itc_pkg::PROD_W'(mag) * itc_pkg::PROD_W'(scale_ff);
   end

   always_comb begin
      scaled = prod_ff[itc_pkg::PROD_W-1:itc_pkg::FRAC_W];
      // truncate, then saturate
      if (|scaled[itc_pkg::PROD_W-itc_pkg::FRAC_W-1:PW]) filt_value = itc_pkg::SAT_MAX;
      else                                              filt_value = scaled[PW-1:0];
   end

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] out_value;
   logic          frame_end;
   logic [31:0]   out_col_ext, out_row_ext;

   always_comb begin
      unique case (cmd.out_sel)
         itc_pkg::SEL_DRAIN: out_value = (pend32 > w_eff) ? upper_q_ff : lower_q_ff;
         itc_pkg::SEL_PASS:  out_value = window_ff[4];
         itc_pkg::SEL_FILT:  out_value = filt_value;
         default:            out_value = window_ff[4];
      endcase
      frame_end   = (out_row32 == h_eff - 32'd1) && (out_col32 == w_eff - 32'd1);
      out_col_ext = out_col32;
      out_row_ext = out_row32;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_out)              rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_result_value  <= out_value;
         rsp_result_row    <= out_row_ext[itc_pkg::RES_ROW_W-1:0];
         rsp_result_column <= out_col_ext[itc_pkg::RES_COL_W-1:0];
         rsp_frame_end     <= frame_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      status.drain        = drain_ff;
      status.pending_zero = (pend_ff == '0);
      status.emit_due     = (pend32 > w_eff);
      status.interior     = (w_eff >= 32'd3) && (h_eff >= 32'd3) &&
                            (out_row32 >= 32'd1) && (out_row32 + 32'd2 <= h_eff) &&
                            (out_col32 >= 32'd1) && (out_col32 + 32'd2 <= w_eff);
      status.out_busy     = rsp_valid_ff && !rsp_ready;
   end

endmodule

`default_nettype wire

/* rtl/image_template_convolution_top.sv */
// 3x3 template convolution over a raster stream of 8-bit gray pixels. Two
// line memories of MAX_WIDTH entries and a 3x3 window feed one shared
// multiply-accumulate unit; interior pixels become min(255, |sum| * scale
// >> 16), border pixels pass through, and each result leaves width + 1
// pixels after its own pixel, with drain words flushing the tail. A pixel
// word that yields no result passes through accept and update, a border or
// drained result adds the output load, and an interior result adds the
// nine taps, which pass one per cycle through the single MAC, then the
// scale multiply and the output load. The line memory read is registered,
// which adds the update state to every word. A finished result waits in
// the output register while the next word is accepted.
// Depends on itc_pkg, itc_req_if, itc_rsp_if, itc_ctrl and itc_datapath.
`default_nettype none

module image_template_convolution_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [itc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [itc_pkg::CSR_DATA_W-1:0] csr_write_data,
   itc_req_if.sink                             req_chan,
   itc_rsp_if.source                           rsp_chan
);

   itc_pkg::dp_cmd_type    cmd;
   itc_pkg::dp_status_type status;
   logic                   req_ready;

   assign req_chan.ready = req_ready;

   itc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   itc_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_pixel_value   (req_chan.pixel_value),
      .req_drain         (req_chan.drain),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_result_value  (rsp_chan.result_value),
      .rsp_result_row    (rsp_chan.result_row),
      .rsp_result_column (rsp_chan.result_column),
      .rsp_frame_end     (rsp_chan.frame_end),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

`default_nettype wire
